// ===== src/p2r_pkg.sv =====
// ----------------------------------------------------------------------------
// p2r_pkg - shared types for the pixel-to-RGBA converter
// Configuration record, register codes and the word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package p2r_pkg;

    localparam int RAW_W      = 32;
    localparam int COORD_W    = 12;
    localparam int CIDX_W     = 12;
    localparam int NUM_W      = 18;   // value * 255, value up to 10 bits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFTS = 3'd0,
        CFG_MAXIMA = 3'd1,
        CFG_LEFT   = 3'd2,
        CFG_TOP    = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5,
        CFG_ENABLE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0]        shifts;
        logic [39:0]        maxima;
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [6:0]         width;
        logic [6:0]         height;
        logic               enable;
    } t_cfg;

    // hit: for a load, index inside the image; for a convert, cursor drawn here
    typedef struct packed {
        logic                      is_load;
        logic                      hit;
        logic [3:0][NUM_W-1:0]     num;
        logic [31:0]               argb;
    } t_work;

    localparam int WORK_W = $bits(t_work);

endpackage

`default_nettype wire

// ===== src/p2r_ram.sv =====
// ----------------------------------------------------------------------------
// p2r_ram - generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module p2r_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/p2r_fifo.sv =====
// ----------------------------------------------------------------------------
// p2r_fifo - short queue between front and back
// Register-based FIFO; full is independent of pop.
// ----------------------------------------------------------------------------
`default_nettype none

module p2r_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_rdata,
    output logic      [CW-1:0]    o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_buf[r_rd];
    assign o_count = r_cnt;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_buf[r_wr] <= i_wdata;
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/p2r_front.sv =====
// ----------------------------------------------------------------------------
// p2r_front - accept and classify
// Extracts channels, forms dividends, runs the cursor hit test and address.
// ----------------------------------------------------------------------------
`default_nettype none

module p2r_front #(
    parameter int DEPTH      = 4096,
    parameter int AW         = 12,
    parameter int COORD_BITS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire p2r_pkg::t_cfg              i_cfg,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_action,
    input  wire logic [p2r_pkg::RAW_W-1:0]  i_raw_pixel,
    input  wire logic [p2r_pkg::COORD_W-1:0] i_pixel_x,
    input  wire logic [p2r_pkg::COORD_W-1:0] i_pixel_y,
    input  wire logic [p2r_pkg::CIDX_W-1:0] i_cursor_index,
    input  wire logic [31:0]                i_cursor_argb,
    output logic                            o_valid,
    input  wire logic                       i_q_ready,
    output p2r_pkg::t_work                  o_work,
    output logic      [AW-1:0]              o_addr
);

    import p2r_pkg::*;

    localparam logic [COORD_W-1:0] CMASK = (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} :
                                           COORD_W'((1 << COORD_BITS) - 1);

    logic              r_valid;
    t_work             r_work, n_work;
    logic [AW-1:0]     r_addr, n_addr;
    logic              w_acc;
    logic [COORD_W-1:0] px, py;
    logic signed [13:0] dx, dy;
    logic              in_x, in_y, idx_ok, ci_ok;
    logic [14:0]       idx;
    logic [31:0]       idx32, ci32;
    logic [31:0]       shifted;
    logic [9:0]        v, mx;

    assign o_ready = !r_valid || i_q_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;
    assign o_addr  = r_addr;

    always_comb begin
        px = i_pixel_x & CMASK;
        py = i_pixel_y & CMASK;
        dx = $signed({2'b00, px}) - $signed({i_cfg.left[12], i_cfg.left});
        dy = $signed({2'b00, py}) - $signed({i_cfg.top[12], i_cfg.top});
        in_x = !dx[13] && (dx[12:0] < {6'd0, i_cfg.width});
        in_y = !dy[13] && (dy[12:0] < {6'd0, i_cfg.height});
        idx  = ({8'd0, dy[6:0]} * {8'd0, i_cfg.width}) + {8'd0, dx[6:0]};
        idx32  = 32'(idx);
        ci32   = 32'(i_cursor_index);
        idx_ok = idx32 < 32'(DEPTH);
        ci_ok  = ci32 < 32'(DEPTH);

        n_work.is_load = i_action;
        n_work.argb    = i_cursor_argb;
        n_work.hit     = i_action ? ci_ok : (i_cfg.enable && in_x && in_y && idx_ok);
        n_addr         = i_action ? ci32[AW-1:0] : idx32[AW-1:0];
        for (int ch = 0; ch < 4; ch++) begin
            shifted = i_raw_pixel >> i_cfg.shifts[5*ch +: 5];
            mx      = i_cfg.maxima[10*ch +: 10];
            v       = shifted[9:0] & mx;
            n_work.num[ch] = {v, 8'd0} - {8'd0, v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_valid <= 1'b1;
                r_work  <= n_work;
                r_addr  <= n_addr;
            end else if (i_q_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/p2r_back.sv =====
// ----------------------------------------------------------------------------
// p2r_back - execute
// Cursor store, eight-stage channel divider, blend and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module p2r_back #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire p2r_pkg::t_cfg  i_cfg,
    input  wire logic           i_head_valid,
    input  wire p2r_pkg::t_work i_head,
    input  wire logic [AW-1:0]  i_head_addr,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic      [7:0]     o_red,
    output logic      [7:0]     o_green,
    output logic      [7:0]     o_blue,
    output logic      [7:0]     o_alpha
);

    import p2r_pkg::*;

    typedef struct packed {
        logic                  valid;
        logic                  is_load;
        logic                  hit;
        logic [3:0][NUM_W-1:0] rem;
        logic [3:0][7:0]       q;
        logic [31:0]           word;
    } t_stage;

    typedef enum logic [1:0] {MODE_KEEP, MODE_FILL, MODE_MIX} t_mode;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic          en;
    t_stage        r_s [8];
    t_stage        n_s [8];
    t_stage        src;
    logic [31:0]   w_rdata;
    logic [NUM_W-1:0] dv;

    logic          r_m_valid, n_m_valid;
    t_mode         r_m_mode, n_m_mode;
    logic [3:0][7:0]  r_m_sel, n_m_sel;
    logic [2:0][15:0] r_m_prod, n_m_prod;
    logic [7:0]    base [4];
    logic [7:0]    ca;

    logic          r_o_valid;

    assign en    = !r_o_valid || i_out_ready;
    assign o_pop = en && i_head_valid;
    assign o_out_valid = r_o_valid;

    p2r_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop && i_head.is_load && i_head.hit),
        .i_waddr (i_head_addr),
        .i_wdata (i_head.argb),
        .i_re    (o_pop && !i_head.is_load),
        .i_raddr (i_head_addr),
        .o_rdata (w_rdata)
    );

    // one quotient bit per stage, MSB first
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (k == 0) begin
                src.valid   = i_head_valid;
                src.is_load = i_head.is_load;
                src.hit     = i_head.hit;
                src.rem     = i_head.num;
                src.q       = '0;
                src.word    = '0;
            end else begin
                src = r_s[k-1];
                if (k == 1) begin
                    src.word = w_rdata;
                end
            end
            n_s[k] = src;
            for (int ch = 0; ch < 4; ch++) begin
                dv = NUM_W'({8'd0, i_cfg.maxima[10*ch +: 10]}) << (7 - k);
                if (src.rem[ch] >= dv) begin
                    n_s[k].rem[ch]      = src.rem[ch] - dv;
                    n_s[k].q[ch][7 - k] = 1'b1;
                end
            end
        end
    end

    for (genvar k = 0; k < 8; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s[k].valid <= 1'b0;
            end else if (en) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    // zero-maximum overrides, blend mode and products
    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            if (i_cfg.maxima[10*ch +: 10] == 10'd0) begin
                base[ch] = (ch == 3) ? 8'hff : 8'h00;
            end else begin
                base[ch] = r_s[7].q[ch];
            end
        end
        ca        = r_s[7].word[31:24];
        n_m_valid = r_s[7].valid && !r_s[7].is_load;
        if (r_s[7].hit && ca == 8'hff) begin
            n_m_mode = MODE_FILL;
        end else if (r_s[7].hit && ca != 8'h00) begin
            n_m_mode = MODE_MIX;
        end else begin
            n_m_mode = MODE_KEEP;
        end
        for (int ch = 0; ch < 3; ch++) begin
            n_m_sel[ch]  = (n_m_mode == MODE_FILL) ? r_s[7].word[16 - 8*ch +: 8] : base[ch];
            n_m_prod[ch] = ({8'd0, r_s[7].word[16 - 8*ch +: 8]} * {8'd0, ca})
                         + ({8'd0, base[ch]} * {8'd0, 8'hff - ca}) + 16'd127;
        end
        n_m_sel[3] = (n_m_mode == MODE_KEEP) ? base[3] : 8'hff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= n_m_valid;
            r_m_mode  <= n_m_mode;
            r_m_sel   <= n_m_sel;
            r_m_prod  <= n_m_prod;
            r_o_valid <= r_m_valid;
            o_red     <= (r_m_mode == MODE_MIX) ? div255(r_m_prod[0]) : r_m_sel[0];
            o_green   <= (r_m_mode == MODE_MIX) ? div255(r_m_prod[1]) : r_m_sel[1];
            o_blue    <= (r_m_mode == MODE_MIX) ? div255(r_m_prod[2]) : r_m_sel[2];
            o_alpha   <= r_m_sel[3];
        end
    end

endmodule

`default_nettype wire

// ===== src/pixel_to_rgba_with_cursor_blend_core.sv =====
// ----------------------------------------------------------------------------
// pixel_to_rgba_with_cursor_blend_core - packed pixel to RGBA with cursor
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one word per pixel or cursor
//   load. action 0 converts raw_pixel at (pixel_x, pixel_y); action 1 writes
//   cursor_argb into the cursor image at cursor_index and gives no result.
//   Output channel (o_out_valid / i_out_ready): one RGBA word per convert.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; write only
//   while no words are in flight. Unknown indexes are ignored.
//   Throughput: one word per clock while the receiver does not stall; the
//   eight-stage restoring divider (one quotient bit per stage) and the
//   cursor RAM (one write port, one registered read port) each take one
//   word a cycle. Reset clears the configuration, the queue pointers and
//   all pipeline valids, but not the pipeline data; the cursor image is not
//   cleared and must be loaded before the cursor is enabled.
//   When the receiver stalls the back pipeline freezes; the front keeps
//   taking words until the four-entry queue and the front register are
//   full, then o_in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_rgba_with_cursor_blend_core #(
    parameter int CURSOR_SIZE = 64,
    parameter int COORD_BITS  = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_action,
    input  wire logic [p2r_pkg::RAW_W-1:0]       i_raw_pixel,
    input  wire logic [p2r_pkg::COORD_W-1:0]     i_pixel_x,
    input  wire logic [p2r_pkg::COORD_W-1:0]     i_pixel_y,
    input  wire logic [p2r_pkg::CIDX_W-1:0]      i_cursor_index,
    input  wire logic [31:0]                     i_cursor_argb,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [7:0]                      o_red,
    output logic      [7:0]                      o_green,
    output logic      [7:0]                      o_blue,
    output logic      [7:0]                      o_alpha,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [p2r_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [p2r_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import p2r_pkg::*;

    localparam int DEPTH  = CURSOR_SIZE * CURSOR_SIZE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int QW     = WORK_W + AW;

    t_cfg            r_cfg;

    // front -> queue
    logic            w_f_valid, w_q_full;
    t_work           w_f_work;
    logic [AW-1:0]   w_f_addr;

    // queue -> back
    logic            w_h_valid, w_pop;
    logic [QW-1:0]   w_h_data;
    t_work           w_h_work;
    logic [AW-1:0]   w_h_addr;
    logic [QCW-1:0]  w_q_count;

    assign o_cfg_ready = 1'b1;

    // configuration registers, truncated to their field widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SHIFTS: r_cfg.shifts <= i_cfg_data[19:0];
                CFG_MAXIMA: r_cfg.maxima <= i_cfg_data[39:0];
                CFG_LEFT:   r_cfg.left   <= $signed(i_cfg_data[12:0]);
                CFG_TOP:    r_cfg.top    <= $signed(i_cfg_data[12:0]);
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[6:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[6:0];
                CFG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    p2r_front #(.DEPTH(DEPTH), .AW(AW), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_action       (i_action),
        .i_raw_pixel    (i_raw_pixel),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_cursor_index (i_cursor_index),
        .i_cursor_argb  (i_cursor_argb),
        .o_valid        (w_f_valid),
        .i_q_ready      (!w_q_full),
        .o_work         (w_f_work),
        .o_addr         (w_f_addr)
    );

    p2r_fifo #(.WIDTH(QW), .DEPTH(QDEPTH), .CW(QCW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_wdata ({w_f_work, w_f_addr}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_h_valid),
        .o_rdata (w_h_data),
        .o_count (w_q_count)
    );

    assign w_h_work = t_work'(w_h_data[QW-1:AW]);
    assign w_h_addr = w_h_data[AW-1:0];

    p2r_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_h_valid),
        .i_head       (w_h_work),
        .i_head_addr  (w_h_addr),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha)
    );

    // queue occupancy never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= QCW'(QDEPTH))
        else $error("queue count beyond depth");

    // an empty queue means the front can always take a word
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_count == '0) |-> o_in_ready)
        else $error("front stalled with empty queue");

    // no result straight after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
